/* rtl/cscd_pkg.sv */
// shared types, constants and tables for the concentric square-to-disk mapper
// no dependencies
package cscd_pkg;

	localparam int FRAC_BITS     = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_LEN      = 24;
	localparam int NSTAGES       = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

	localparam int DIV_STEPS = FRAC_BITS + 1;
	localparam int QW        = FRAC_BITS + 1;
	localparam int QIW       = $clog2(QW);
	localparam int RW        = 17;
	localparam int DW        = 18;
	localparam int REMW      = FRAC_BITS + 18;
	localparam int XW        = 34;
	localparam int ZW        = 33;
	localparam int AIW       = $clog2(ATAN_LEN);

	localparam logic [29:0] PI_QUARTER = 30'd843314857;
	localparam logic [29:0] INV_GAIN   = 30'd652032874;

	localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
		30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
		30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
		30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255, 30'd127
	};

	typedef enum logic [1:0] {
		SEC_E = 2'd0,
		SEC_N = 2'd1,
		SEC_W = 2'd2,
		SEC_S = 2'd3
	} sector_t;

	typedef struct packed {
		logic [REMW-1:0] rem;
		logic [DW-1:0]   dvs;
		logic [QW-1:0]   quo;
		logic [RW-1:0]   rad;
		sector_t         sector;
		logic            neg;
	} div_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		sector_t              sector;
	} rot_t;

endpackage

/* rtl/concentric_square_to_disk_map.sv */
// top level of the concentric square-to-disk mapper: sector pick, divider chain,
// angle and gain scaling, cordic chain, quarter turn and rounding
// depends on cscd_pkg, cscd_div_cell, cscd_rot_cell

// Maps one point of the unit square (unsigned Q0.16) to the unit disk (signed
// Q1.15) by the concentric mapping. One item is accepted per clock while
// square_stall is low. An item passes the front register, one divider cell per
// quotient bit, the scaling register, one cordic cell per micro-rotation and
// the output register. Every stage holds its item and lets earlier empty
// stages fill, so a stalled output does not stop intake until the chain is full.
module concentric_square_to_disk_map (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               square_valid,
	output logic               square_stall,
	input  logic [15:0]        square_x,
	input  logic [15:0]        square_y,
	output logic               disk_valid,
	input  logic               disk_stall,
	output logic signed [15:0] disk_x,
	output logic signed [15:0] disk_y
);

	localparam int DS = cscd_pkg::DIV_STEPS;
	localparam int NS = cscd_pkg::NSTAGES;
	localparam int XW = cscd_pkg::XW;

	// front stage: sector and divider operands
	logic signed [16:0] a, b;
	logic signed [17:0] sum_ab;
	logic [16:0]        abs_a, abs_b, nm, dm;
	cscd_pkg::div_t     front;
	logic               front_v_s1;
	cscd_pkg::div_t     front_s1;
	logic               front_rdy;

	// divider chain, quotient msb first
	logic           dv [DS+1];
	logic           dr [DS+1];
	cscd_pkg::div_t dd [DS+1];

	always_comb begin
		// 2x - 1 in q1.16: flipping the top bit subtracts one
		a      = $signed({~square_x[15], square_x[14:0], 1'b0});
		b      = $signed({~square_y[15], square_y[14:0], 1'b0});
		sum_ab = 18'(a) + 18'(b);
		abs_a  = a[16] ? 17'(-a) : 17'(a);
		abs_b  = b[16] ? 17'(-b) : 17'(b);
		front  = '0;
		if (!sum_ab[17] && sum_ab != '0) begin
			if (a > b) begin
				front.sector = cscd_pkg::SEC_E;
				nm = abs_b; dm = abs_a; front.neg = b[16];
			end else begin
				front.sector = cscd_pkg::SEC_N;
				nm = abs_a; dm = abs_b; front.neg = !a[16] && a != '0;
			end
		end else begin
			if (a < b) begin
				front.sector = cscd_pkg::SEC_W;
				nm = abs_b; dm = abs_a; front.neg = !b[16];
			end else begin
				front.sector = cscd_pkg::SEC_S;
				nm = abs_a; dm = abs_b; front.neg = a[16];
			end
		end
		front.rad = dm;
		front.rem = (cscd_pkg::REMW'(nm) << (cscd_pkg::FRAC_BITS + 1))
			+ cscd_pkg::REMW'(dm);
		// origin: a unit divisor keeps the zero numerator at a zero quotient
		front.dvs = (dm == '0) ? cscd_pkg::DW'(2) : {dm, 1'b0};
	end

	assign front_rdy    = !front_v_s1 || dr[0];
	assign square_stall = !front_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_v_s1 <= 1'b0;
		end else if (front_rdy) begin
			front_v_s1 <= square_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (front_rdy && square_valid) begin
			front_s1 <= front;
		end
	end

	assign dv[0] = front_v_s1;
	assign dd[0] = front_s1;

	for (genvar j = 0; j < DS; j++) begin : g_div
		cscd_div_cell u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (cscd_pkg::QIW'(cscd_pkg::FRAC_BITS - j)),
			.valid_up (dv[j]),
			.data_up  (dd[j]),
			.ready_up (dr[j]),
			.valid_dn (dv[j+1]),
			.data_dn  (dd[j+1]),
			.ready_dn (dr[j+1])
		);
	end

	// angle and gain scaling
	logic [cscd_pkg::QW+29:0] zp;
	logic [cscd_pkg::RW+29:0] xp;
	logic [30:0]              zmag;
	cscd_pkg::rot_t           prep;
	logic                     rv [NS+1];
	logic                     rr [NS+1];
	cscd_pkg::rot_t           rd [NS+1];
	logic                     prep_v_s2;
	cscd_pkg::rot_t           prep_s2;

	always_comb begin
		zp   = dd[DS].quo * cscd_pkg::PI_QUARTER
			+ (cscd_pkg::QW+30)'(1 << (cscd_pkg::FRAC_BITS - 1));
		zmag = 31'(zp >> cscd_pkg::FRAC_BITS);
		xp   = dd[DS].rad * cscd_pkg::INV_GAIN;
		prep.x      = XW'(xp >> 16);
		prep.y      = '0;
		prep.z      = dd[DS].neg ? -cscd_pkg::ZW'(zmag) : cscd_pkg::ZW'(zmag);
		prep.sector = dd[DS].sector;
	end

	assign dr[DS] = !prep_v_s2 || rr[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_v_s2 <= 1'b0;
		end else if (dr[DS]) begin
			prep_v_s2 <= dv[DS];
		end
	end

	always_ff @(posedge clk) begin
		if (dr[DS] && dv[DS]) begin
			prep_s2 <= prep;
		end
	end

	assign rv[0] = prep_v_s2;
	assign rd[0] = prep_s2;

	for (genvar i = 0; i < NS; i++) begin : g_rot
		cscd_rot_cell u_rot (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (cscd_pkg::AIW'(i)),
			.valid_up (rv[i]),
			.data_up  (rd[i]),
			.ready_up (rr[i]),
			.valid_dn (rv[i+1]),
			.data_dn  (rd[i+1]),
			.ready_dn (rr[i+1])
		);
	end

	// quarter turn, round to q1.15, saturate
	function automatic logic [15:0] to_q15(input logic signed [XW-1:0] v);
		logic signed [XW:0]    s;
		logic signed [XW-15:0] o;
		s = (XW+1)'(v) + (XW+1)'(16384);
		o = s[XW:15];
		if (o > (XW-14)'(32767)) begin
			return 16'h7fff;
		end else if (o < -(XW-14)'(32768)) begin
			return 16'h8000;
		end
		return o[15:0];
	endfunction

	logic signed [XW-1:0] qx, qy;
	logic                 out_rdy;

	always_comb begin
		case (rd[NS].sector)
			cscd_pkg::SEC_N: begin qx = -rd[NS].y; qy = rd[NS].x; end
			cscd_pkg::SEC_W: begin qx = -rd[NS].x; qy = -rd[NS].y; end
			cscd_pkg::SEC_S: begin qx = rd[NS].y; qy = -rd[NS].x; end
			default: begin qx = rd[NS].x; qy = rd[NS].y; end
		endcase
	end

	assign out_rdy = !disk_valid || !disk_stall;
	assign rr[NS]  = out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_valid <= 1'b0;
		end else if (out_rdy) begin
			disk_valid <= rv[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && rv[NS]) begin
			disk_x <= to_q15(qx);
			disk_y <= to_q15(qy);
		end
	end

endmodule

/* rtl/cscd_div_cell.sv */
// one restoring-division cell: settles one quotient bit of the sector ratio
// depends on cscd_pkg
module cscd_div_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [cscd_pkg::QIW-1:0] idx,
	input  logic                   valid_up,
	input  cscd_pkg::div_t         data_up,
	output logic                   ready_up,
	output logic                   valid_dn,
	output cscd_pkg::div_t         data_dn,
	input  logic                   ready_dn
);

	logic [cscd_pkg::REMW-1:0] sub;
	logic [cscd_pkg::REMW:0]   trial;
	cscd_pkg::div_t            nxt;

	always_comb begin
		sub   = cscd_pkg::REMW'(data_up.dvs) << idx;
		trial = {1'b0, data_up.rem} - {1'b0, sub};
		nxt   = data_up;
		if (!trial[cscd_pkg::REMW]) begin
			nxt.rem      = trial[cscd_pkg::REMW-1:0];
			nxt.quo[idx] = 1'b1;
		end
	end

	assign ready_up = !valid_dn || ready_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_dn <= 1'b0;
		end else if (ready_up) begin
			valid_dn <= valid_up;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && valid_up) begin
			data_dn <= nxt;
		end
	end

endmodule

/* rtl/cscd_rot_cell.sv */
// one cordic micro-rotation cell in rotation mode
// depends on cscd_pkg
module cscd_rot_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [cscd_pkg::AIW-1:0] idx,
	input  logic                   valid_up,
	input  cscd_pkg::rot_t         data_up,
	output logic                   ready_up,
	output logic                   valid_dn,
	output cscd_pkg::rot_t         data_dn,
	input  logic                   ready_dn
);

	logic signed [cscd_pkg::XW-1:0] dx;
	logic signed [cscd_pkg::XW-1:0] dy;
	logic signed [cscd_pkg::ZW-1:0] at;
	cscd_pkg::rot_t                 nxt;

	always_comb begin
		dx  = data_up.y >>> idx;
		dy  = data_up.x >>> idx;
		at  = cscd_pkg::ZW'(cscd_pkg::ATAN_TAB[idx]);
		nxt = data_up;
		if (!data_up.z[cscd_pkg::ZW-1]) begin
			nxt.x = data_up.x - dx;
			nxt.y = data_up.y + dy;
			nxt.z = data_up.z - at;
		end else begin
			nxt.x = data_up.x + dx;
			nxt.y = data_up.y - dy;
			nxt.z = data_up.z + at;
		end
	end

	assign ready_up = !valid_dn || ready_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_dn <= 1'b0;
		end else if (ready_up) begin
			valid_dn <= valid_up;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && valid_up) begin
			data_dn <= nxt;
		end
	end

endmodule

/* rtl/cscd_checker.sv */
// port-level checker for the concentric square-to-disk mapper, bound to the top
// depends on cscd_pkg and concentric_square_to_disk_map
module cscd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               square_valid,
	input logic               square_stall,
	input logic               disk_valid,
	input logic               disk_stall,
	input logic signed [15:0] disk_x,
	input logic signed [15:0] disk_y
);

	localparam int DEPTH = cscd_pkg::DIV_STEPS + cscd_pkg::NSTAGES + 3;
	localparam int CW    = $clog2(DEPTH + 2);

	// items accepted but not yet delivered
	logic [CW-1:0] cnt_q;
	logic          acc_in, acc_out;

	assign acc_in  = square_valid && !square_stall;
	assign acc_out = disk_valid && !disk_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CW'(acc_in) - CW'(acc_out);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		disk_valid && disk_stall |=> disk_valid && $stable(disk_x) && $stable(disk_y))
		else $error("stalled result changed");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		disk_valid |-> cnt_q != '0)
		else $error("result without an item in flight");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("more items in flight than stages");

	a_disk: assert property (@(posedge clk) disable iff (!arst_n)
		disk_valid |-> !(disk_x == -16'sd32768 && disk_y == -16'sd32768))
		else $error("result outside the unit disk");

endmodule

bind concentric_square_to_disk_map cscd_checker u_cscd_checker (.*);

/* verif/concentric_square_to_disk_map_tb.sv */
// testbench for concentric_square_to_disk_map: drives square points, predicts the disk point
// with a bit-exact fixed-point sector/ratio/cordic model and checks every result in order
// depends on cscd_pkg and the rtl of concentric_square_to_disk_map
module concentric_square_to_disk_map_tb;

	localparam int IDLE_LIMIT = 2000;
	localparam int LATENCY    = cscd_pkg::FRAC_BITS + cscd_pkg::CORDIC_STAGES + 4;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
	} disk_pt_t;

	logic               clk;
	logic               arst_n;
	logic               square_valid;
	logic               square_stall;
	logic [15:0]        square_x;
	logic [15:0]        square_y;
	logic               disk_valid;
	logic               disk_stall;
	logic signed [15:0] disk_x;
	logic signed [15:0] disk_y;

	disk_pt_t disk_expected[$];
	int       errors;
	int       idle_cycles;
	int       stall_left;
	bit       calm;

	concentric_square_to_disk_map dut (
		.clk(clk), .arst_n(arst_n),
		.square_valid(square_valid), .square_stall(square_stall),
		.square_x(square_x), .square_y(square_y),
		.disk_valid(disk_valid), .disk_stall(disk_stall),
		.disk_x(disk_x), .disk_y(disk_y)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	// |n|/|d| in Q.FRAC_BITS, nearest with ties away, sign of n/d
	function automatic longint sector_ratio(longint n, longint d);
		longint nm, dm, q;
		nm = (n < 0) ? -n : n;
		dm = (d < 0) ? -d : d;
		if (dm == 0)
			return 0;
		q = ((nm <<< (cscd_pkg::FRAC_BITS + 1)) + dm) / (2 * dm);
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic logic signed [15:0] round_q15(longint v);
		longint o;
		o = floor_shift(v + (64'sd1 <<< 14), 15);
		if (o > 32767)
			o = 32767;
		if (o < -32768)
			o = -32768;
		return o[15:0];
	endfunction

	function automatic disk_pt_t map_to_disk(logic [15:0] sx, logic [15:0] sy);
		longint a, b, r, s, x, y, z, t, m, dx, dy;
		cscd_pkg::sector_t sec;
		disk_pt_t res;
		a = 2 * longint'(sx) - 65536;
		b = 2 * longint'(sy) - 65536;
		if (a > -b) begin
			if (a > b) begin
				sec = cscd_pkg::SEC_E; r = a; s = sector_ratio(b, a);
			end else begin
				sec = cscd_pkg::SEC_N; r = b; s = -sector_ratio(a, b);
			end
		end else begin
			if (a < b) begin
				sec = cscd_pkg::SEC_W; r = -a; s = sector_ratio(b, a);
			end else begin
				sec = cscd_pkg::SEC_S; r = -b; s = (b != 0) ? -sector_ratio(a, b) : 0;
			end
		end
		x = floor_shift(r * longint'(cscd_pkg::INV_GAIN), 16);
		y = 0;
		m = (s < 0) ? -s : s;
		z = (m * longint'(cscd_pkg::PI_QUARTER) + (64'sd1 <<< (cscd_pkg::FRAC_BITS - 1)))
			>>> cscd_pkg::FRAC_BITS;
		if (s < 0)
			z = -z;
		for (int i = 0; i < cscd_pkg::NSTAGES; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(cscd_pkg::ATAN_TAB[i]);
			end else begin
				x += dx; y -= dy; z += longint'(cscd_pkg::ATAN_TAB[i]);
			end
		end
		case (sec)
			cscd_pkg::SEC_N: begin
				t = x; x = -y; y = t;
			end
			cscd_pkg::SEC_W: begin
				x = -x; y = -y;
			end
			cscd_pkg::SEC_S: begin
				t = x; x = y; y = -t;
			end
			default: ;
		endcase
		res.x = round_q15(x);
		res.y = round_q15(y);
		return res;
	endfunction

	// valid stays high from one item to the next unless an idle burst comes between
	task automatic send_point(logic [15:0] sx, logic [15:0] sy);
		if (!calm && $urandom_range(0, 5) == 0) begin
			square_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		square_valid <= 1'b1;
		square_x     <= sx;
		square_y     <= sy;
		@(posedge clk);
		while (square_stall)
			@(posedge clk);
		disk_expected = {disk_expected, map_to_disk(sx, sy)};
	endtask

	// receiver idling in random bursts
	always @(posedge clk) begin
		if (!arst_n || calm) begin
			disk_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			disk_stall <= (stall_left != 1);
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 7);
			disk_stall <= 1'b1;
		end
	end

	always @(posedge clk) begin
		disk_pt_t e;
		if (arst_n && disk_valid && !disk_stall) begin
			if (disk_expected.size() == 0) begin
				$display("%0t: unexpected item x=%0d y=%0d", $time, disk_x, disk_y);
				errors++;
			end else begin
				e = disk_expected.pop_front();
				if (disk_x !== e.x) begin
					$display("%0t: disk_x expected %0d actual %0d", $time, e.x, disk_x);
					errors++;
				end
				if (disk_y !== e.y) begin
					$display("%0t: disk_y expected %0d actual %0d", $time, e.y, disk_y);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((square_valid && !square_stall) || (disk_valid && !disk_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("concentric_square_to_disk_map_tb failed");
			$finish;
		end
	end

	task automatic test_corners();
		logic [15:0] v[5] = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFE, 16'hFFFF};
		foreach (v[i])
			foreach (v[j])
				send_point(v[i], v[j]);
	endtask

	// diagonals and sector borders
	task automatic test_sector_borders();
		logic [15:0] t;
		for (int i = 0; i < 40; i++) begin
			t = 16'($urandom);
			send_point(t, t);
			send_point(t, 16'h0000 - t);
			send_point(t, t + 16'(i % 3) - 16'd1);
		end
	endtask

	task automatic test_random_points(int n);
		for (int i = 0; i < n; i++)
			send_point(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
	endtask

	initial begin
		errors       = 0;
		idle_cycles  = 0;
		stall_left   = 0;
		calm         = 0;
		arst_n       = 1'b0;
		square_valid = 1'b0;
		square_x     = '0;
		square_y     = '0;
		disk_stall   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		test_sector_borders();
		test_random_points(1200);
		calm = 1;
		test_random_points(200);
		square_valid <= 1'b0;
		while (disk_expected.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && disk_expected.size() == 0)
			$display("concentric_square_to_disk_map_tb passed");
		else
			$display("concentric_square_to_disk_map_tb failed");
		$finish;
	end

endmodule
